### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NUCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define NUCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/nuce_pkg.sv
package nuce_pkg;

   localparam logic [1:0] KIND_BYTE     = 2'd0;
   localparam logic [1:0] KIND_END_COMP = 2'd1;
   localparam logic [1:0] KIND_END_NAME = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5a;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_Z    = 8'h7a;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_UNDER   = 8'h5f;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
      logic       end_of_uri;
   } rsp_type;

   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_LIT,
      BODY_HEX,
      BODY_DOTS
   } body_type;

   // one run of output characters, as decided by the front
   typedef struct packed {
      logic       lead_slash;
      body_type   body;
      logic [7:0] data_byte;
      logic       uri_end;
   } desc_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   typedef struct packed {
      logic inside_component;
      logic name_has_components;
   } front_status_type;

   function automatic logic passes_through(input logic [7:0] x);
      return (x >= CH_0 && x <= CH_9) || (x >= CH_UP_A && x <= CH_UP_Z) ||
             (x >= CH_LO_A && x <= CH_LO_Z) || x == CH_PLUS || x == CH_MINUS ||
             x == CH_DOT || x == CH_UNDER;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = CH_0 + {4'd0, nib};
      end else begin
         r = CH_UP_A + {4'd0, nib} - 8'd10;
      end
      return r;
   endfunction

endpackage

### design/nuce_front.sv
module nuce_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  nuce_pkg::req_type           req_data,
   input  logic                        q_full,
   output logic                        push,
   output nuce_pkg::desc_type          push_data,
   output nuce_pkg::front_status_type  status
);

   logic inside_ff, inside_in;
   logic saw_non_dot_ff, saw_non_dot_in;
   logic has_comp_ff, has_comp_in;
   logic accept;
   nuce_pkg::desc_type d;

   assign accept = req_valid && !q_full;

   always_comb begin
      d.lead_slash   = 1'b0;
      d.body         = nuce_pkg::BODY_NONE;
      d.data_byte    = req_data.data_byte;
      d.uri_end      = 1'b0;
      inside_in      = inside_ff;
      saw_non_dot_in = saw_non_dot_ff;
      has_comp_in    = has_comp_ff;
      unique case (req_data.kind)
         nuce_pkg::KIND_BYTE: begin
            d.lead_slash   = !inside_ff;
            d.body         = nuce_pkg::passes_through(req_data.data_byte) ?
                             nuce_pkg::BODY_LIT : nuce_pkg::BODY_HEX;
            inside_in      = 1'b1;
            has_comp_in    = 1'b1;
            saw_non_dot_in = (inside_ff && saw_non_dot_ff) ||
                             (req_data.data_byte != nuce_pkg::CH_DOT);
         end
         nuce_pkg::KIND_END_COMP: begin
            d.lead_slash   = !inside_ff;
            // a freshly opened component is empty, so it always gets dots
            d.body         = (!inside_ff || !saw_non_dot_ff) ?
                             nuce_pkg::BODY_DOTS : nuce_pkg::BODY_NONE;
            inside_in      = 1'b0;
            saw_non_dot_in = 1'b0;
            has_comp_in    = 1'b1;
         end
         nuce_pkg::KIND_END_NAME: begin
            if (inside_ff) begin
               d.body = !saw_non_dot_ff ? nuce_pkg::BODY_DOTS : nuce_pkg::BODY_NONE;
            end else if (!has_comp_ff) begin
               d.lead_slash = 1'b1;
               d.uri_end    = 1'b1;
            end
            inside_in      = 1'b0;
            saw_non_dot_in = 1'b0;
            has_comp_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign push      = accept && (d.lead_slash || d.body != nuce_pkg::BODY_NONE);
   assign push_data = d;
   assign status    = '{inside_component: inside_ff, name_has_components: has_comp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff      <= 1'b0;
         saw_non_dot_ff <= 1'b0;
         has_comp_ff    <= 1'b0;
      end else if (accept) begin
         inside_ff      <= inside_in;
         saw_non_dot_ff <= saw_non_dot_in;
         has_comp_ff    <= has_comp_in;
      end
   end

endmodule

### design/nuce_queue.sv
module nuce_queue #(
   parameter int DEPTH = nuce_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  nuce_pkg::desc_type      push_data,
   input  logic                    pop,
   output nuce_pkg::desc_type      pop_data,
   output nuce_pkg::q_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   nuce_pkg::desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign pop_data         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/nuce_back.sv
module nuce_back (
   input  logic                    clock,
   input  logic                    reset,
   input  nuce_pkg::desc_type      desc,
   input  logic                    desc_avail,
   output logic                    pop,
   output logic                    rsp_valid,
   output nuce_pkg::rsp_type       rsp_data,
   input  logic                    rsp_stall
);

   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   nuce_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic       load;
   logic [2:0] body_len;
   logic [2:0] total;
   logic [1:0] body_pos;
   logic       is_last;

   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (desc.body)
         nuce_pkg::BODY_LIT:  body_len = 3'd1;
         nuce_pkg::BODY_HEX:  body_len = 3'd3;
         nuce_pkg::BODY_DOTS: body_len = 3'd3;
         default:             body_len = 3'd0;
      endcase
      total    = body_len + {2'b00, desc.lead_slash};
      is_last  = ({1'b0, step_ff} == total - 3'd1);
      body_pos = step_ff - {1'b0, desc.lead_slash};

      rsp_data_in.last_of_run = is_last;
      rsp_data_in.end_of_uri  = desc.uri_end;
      if (desc.lead_slash && step_ff == 2'd0) begin
         rsp_data_in.out_char = nuce_pkg::CH_SLASH;
      end else begin
         case (desc.body)
            nuce_pkg::BODY_LIT: rsp_data_in.out_char = desc.data_byte;
            nuce_pkg::BODY_HEX: begin
               if (body_pos == 2'd0) begin
                  rsp_data_in.out_char = nuce_pkg::CH_PERCENT;
               end else if (body_pos == 2'd1) begin
                  rsp_data_in.out_char = nuce_pkg::hex_char(desc.data_byte[7:4]);
               end else begin
                  rsp_data_in.out_char = nuce_pkg::hex_char(desc.data_byte[3:0]);
               end
            end
            default: rsp_data_in.out_char = nuce_pkg::CH_DOT;
         endcase
      end

      pop          = load && desc_avail && is_last;
      rsp_valid_in = load ? desc_avail : rsp_valid_ff;
      step_in      = step_ff;
      if (load && desc_avail) begin
         step_in = is_last ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && desc_avail) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/name_uri_component_escaper.sv
// channel   dir  ports                           payload
// req       in   req_valid, req_stall, req_data  kind, data_byte
// rsp       out  rsp_valid, rsp_stall, rsp_data  out_char, last_of_run, end_of_uri
//
// one output character per cycle unless rsp_stall holds it or the queue is empty; an
// input item gives 0 to 4 characters, so an escaped byte gives 3 and a plain byte 1
// the front classifies in the cycle of the transfer and queues a run descriptor
// reset is synchronous; no clearing pass
// rsp_stall holds the output register; the queue keeps taking items until it fills
`include "assert_macros.svh"

module name_uri_component_escaper #(
   parameter int QUEUE_DEPTH = nuce_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nuce_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nuce_pkg::rsp_type  rsp_data
);

   logic                        push;
   logic                        pop;
   nuce_pkg::desc_type          push_desc;
   nuce_pkg::desc_type          head_desc;
   nuce_pkg::q_status_type      q_status;
   nuce_pkg::front_status_type  front_status;

   nuce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_status.full),
      .push      (push),
      .push_data (push_desc),
      .status    (front_status)
   );

   nuce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_desc),
      .pop       (pop),
      .pop_data  (head_desc),
      .status    (q_status)
   );

   nuce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc       (head_desc),
      .desc_avail (q_status.not_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

   assign req_stall = q_status.full;

   `NUCE_ASSERT_NOW(a_rise_needs_queue, clock, reset, $rose(rsp_valid), $past(q_status.not_empty))
   `NUCE_ASSERT_NOW(a_eou_is_last, clock, reset, rsp_valid && rsp_data.end_of_uri, rsp_data.last_of_run)
   `NUCE_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, q_status.not_empty)
   `NUCE_ASSERT_NEXT(a_end_name_clears, clock, reset, req_valid && !req_stall && req_data.kind == nuce_pkg::KIND_END_NAME, !front_status.inside_component && !front_status.name_has_components)

endmodule

### sim/tb_name_uri_component_escaper.sv
`timescale 1ns / 100ps

module tb_name_uri_component_escaper;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data_byte;
      string      chars;   // empty: checked against the predictor only
      bit         eou;
   } stim_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   nuce_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   nuce_pkg::rsp_type rsp_data;

   stim_row_type      stim_table[$];
   stim_row_type      item_rows_q[$];   // one entry per item driven, in order
   nuce_pkg::rsp_type uri_chars_q[$];   // characters still to come out
   nuce_pkg::rsp_type run_q[$];         // characters caused by the latest transfer

   bit in_comp          = 1'b0;
   bit comp_has_non_dot = 1'b0;
   bit name_started     = 1'b0;
   bit no_gaps          = 1'b0;
   int mismatches       = 0;
   int sent_items       = 0;
   int stall_left       = 0;
   int calm_left        = 0;

   name_uri_component_escaper DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void put_char(input logic [7:0] c, input bit eou);
      nuce_pkg::rsp_type r;
      r.out_char    = c;
      r.last_of_run = 1'b0;
      r.end_of_uri  = eou;
      run_q.push_back(r);
   endfunction

   function automatic void open_comp();
      if (!in_comp) begin
         put_char(nuce_pkg::CH_SLASH, 1'b0);
         in_comp          = 1'b1;
         comp_has_non_dot = 1'b0;
         name_started     = 1'b1;
      end
   endfunction

   function automatic void close_comp();
      open_comp();
      // empty or dots-only components get three extra dots
      if (!comp_has_non_dot) begin
         for (int k = 0; k < 3; k++) put_char(nuce_pkg::CH_DOT, 1'b0);
      end
      in_comp          = 1'b0;
      comp_has_non_dot = 1'b0;
   endfunction

   function automatic void escape_item(input nuce_pkg::req_type r);
      string hex = "0123456789ABCDEF";
      run_q.delete();
      case (r.kind)
         nuce_pkg::KIND_BYTE: begin
            open_comp();
            if (r.data_byte != nuce_pkg::CH_DOT) comp_has_non_dot = 1'b1;
            if (r.data_byte inside {[nuce_pkg::CH_0:nuce_pkg::CH_9],
                                    [nuce_pkg::CH_UP_A:nuce_pkg::CH_UP_Z],
                                    [nuce_pkg::CH_LO_A:nuce_pkg::CH_LO_Z],
                                    nuce_pkg::CH_PLUS, nuce_pkg::CH_MINUS,
                                    nuce_pkg::CH_DOT, nuce_pkg::CH_UNDER}) begin
               put_char(r.data_byte, 1'b0);
            end else begin
               put_char(nuce_pkg::CH_PERCENT, 1'b0);
               put_char(hex[r.data_byte[7:4]], 1'b0);
               put_char(hex[r.data_byte[3:0]], 1'b0);
            end
         end
         nuce_pkg::KIND_END_COMP: close_comp();
         nuce_pkg::KIND_END_NAME: begin
            if (in_comp) begin
               close_comp();
            end else if (!name_started) begin
               put_char(nuce_pkg::CH_SLASH, 1'b1);
            end
            in_comp          = 1'b0;
            comp_has_non_dot = 1'b0;
            name_started     = 1'b0;
         end
         default: ;
      endcase
      if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // prediction and checking both follow the transfers seen on the ports
   always @(posedge clock) begin
      stim_row_type      row;
      nuce_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            row = item_rows_q.pop_front();
            escape_item(req_data);
            if (row.chars.len() > 0) begin
               run_q.delete();
               for (int i = 0; i < row.chars.len(); i++) put_char(row.chars[i], row.eou);
               run_q[run_q.size() - 1].last_of_run = 1'b1;
            end
            foreach (run_q[i]) uri_chars_q.push_back(run_q[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (uri_chars_q.size() == 0) begin
               report_mismatch($sformatf("char %h with nothing expected", rsp_data.out_char));
            end else begin
               want = uri_chars_q.pop_front();
               if (rsp_data.out_char !== want.out_char)
                  report_mismatch($sformatf("out_char %h, want %h",
                                            rsp_data.out_char, want.out_char));
               if (rsp_data.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b on %h, want %b",
                                            rsp_data.last_of_run, want.out_char,
                                            want.last_of_run));
               if (rsp_data.end_of_uri !== want.end_of_uri)
                  report_mismatch($sformatf("end_of_uri %b on %h, want %b",
                                            rsp_data.end_of_uri, want.out_char,
                                            want.end_of_uri));
            end
         end
      end
   end

   // output back-pressure: short stalls, a few long ones, and calm stretches
   always @(posedge clock) begin
      int r;
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               calm_left = $urandom_range(20, 80);
            end else if (r < 50) begin
               stall_left = gap_len();
            end
         end
      end
   end

   function automatic void add_row(input logic [1:0] kind, input logic [7:0] data,
                                   input string chars, input bit eou);
      stim_row_type row;
      row.kind      = kind;
      row.data_byte = data;
      row.chars     = chars;
      row.eou       = eou;
      stim_table.push_back(row);
   endfunction

   function automatic logic [7:0] pick_byte(input int style);
      string plain = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+-._";
      case (style)
         0: return nuce_pkg::CH_DOT;
         1: return plain[$urandom_range(0, plain.len() - 1)];
         2: return 8'($urandom_range(0, 255));
         default: return $urandom_range(0, 1) ? nuce_pkg::CH_DOT : 8'($urandom_range(0, 255));
      endcase
   endfunction

   // returns at the edge of the transfer with valid still high
   task automatic drive_item(input logic [1:0] kind, input logic [7:0] data,
                             input string chars, input bit eou);
      stim_row_type      row;
      nuce_pkg::req_type item;
      int                gap;
      row.kind       = kind;
      row.data_byte  = data;
      row.chars      = chars;
      row.eou        = eou;
      item.kind      = kind;
      item.data_byte = data;
      gap = (no_gaps || $urandom_range(0, 1)) ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item_rows_q.push_back(row);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind != nuce_pkg::KIND_UNUSED) sent_items++;
   endtask

   task automatic drain_uri();
      req_valid <= 1'b0;
      @(posedge clock);
      while (uri_chars_q.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed names, with stray items mixed in now and then
   task automatic drive_name();
      int n_comp;
      int len;
      int style;
      n_comp  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int c = 0; c < n_comp; c++) begin
         style = $urandom_range(0, 3);
         len   = $urandom_range(0, 5);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0)
               drive_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), "", 1'b0);
            drive_item(nuce_pkg::KIND_BYTE, pick_byte(style), "", 1'b0);
         end
         // the last component is sometimes left open for the end of name to close
         if (c < n_comp - 1 || $urandom_range(0, 1))
            drive_item(nuce_pkg::KIND_END_COMP, 8'($urandom_range(0, 255)), "", 1'b0);
      end
      drive_item(nuce_pkg::KIND_END_NAME, 8'($urandom_range(0, 255)), "", 1'b0);
   endtask

   initial begin
      bit paused;
      paused = 1'b0;

      add_row(nuce_pkg::KIND_END_NAME, 8'h00, "/", 1'b1);       // empty name
      add_row(nuce_pkg::KIND_BYTE,     8'h00, "/%00", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     8'hff, "%FF", 1'b0);
      add_row(nuce_pkg::KIND_END_COMP, 8'h00, "", 1'b0);
      add_row(nuce_pkg::KIND_END_COMP, 8'h00, "/...", 1'b0);    // empty component
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_DOT, "/.", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_DOT, ".", 1'b0);
      add_row(nuce_pkg::KIND_END_COMP, 8'h00, "...", 1'b0);     // dots-only component
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_0, "/0", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_9, "9", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_UP_A, "A", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_LO_Z, "z", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_PLUS, "+", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_MINUS, "-", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_UNDER, "_", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     8'h2f, "", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     8'h40, "", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     8'h7b, "", 1'b0);
      add_row(nuce_pkg::KIND_END_NAME, 8'h00, "", 1'b0);
      add_row(nuce_pkg::KIND_UNUSED,   8'haa, "", 1'b0);
      add_row(nuce_pkg::KIND_BYTE,     nuce_pkg::CH_DOT, "/.", 1'b0);
      add_row(nuce_pkg::KIND_END_NAME, 8'h55, "...", 1'b0);     // end of name closes dots
      add_row(nuce_pkg::KIND_END_COMP, 8'h00, "/...", 1'b0);
      add_row(nuce_pkg::KIND_END_NAME, 8'h00, "", 1'b0);
      add_row(nuce_pkg::KIND_END_NAME, 8'h00, "/", 1'b1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         drive_item(stim_table[i].kind, stim_table[i].data_byte,
                    stim_table[i].chars, stim_table[i].eou);
      drain_uri();

      while (sent_items < 100) begin
         if (!paused && sent_items >= 60) begin
            drain_uri();
            paused = 1'b1;
         end
         drive_name();
      end
      drain_uri();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && uri_chars_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
